// ===== design/tag_strip_entity_decoder_defines.svh =====
// Assertion macros shared by the tag strip entity decoder modules.
// No dependencies; included by each module that carries assertions.
`ifndef TAG_STRIP_ENTITY_DECODER_DEFINES_SVH
`define TAG_STRIP_ENTITY_DECODER_DEFINES_SVH

// same-cycle implication under asynchronous active-low reset
`define TSED_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under asynchronous active-low reset
`define TSED_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tsed_pkg.sv =====
// Package for the tag strip entity decoder: result record types, byte codes,
// entity table and the entity matcher function. No dependencies.
`default_nettype none

package tsed_pkg;

	localparam int MAX_RES    = 6;
	localparam int HELD_DEPTH = 4;
	localparam int NUM_ENT    = 5;
	localparam int ENT_MAXLEN = 5;

	localparam logic [7:0] CHR_AMP  = 8'h26;
	localparam logic [7:0] CHR_LT   = 8'h3c;
	localparam logic [7:0] CHR_GT   = 8'h3e;
	localparam logic [7:0] CHR_QUOT = 8'h22;
	localparam logic [7:0] CHR_APOS = 8'h27;

	localparam logic [7:0] ENT_BODY [NUM_ENT][ENT_MAXLEN] = '{
		'{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
		'{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
		'{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
		'{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},
		'{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b}
	};
	localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd5};
	localparam logic [7:0] ENT_DEC [NUM_ENT] = '{CHR_AMP, CHR_LT, CHR_GT, CHR_QUOT, CHR_APOS};

	typedef logic [HELD_DEPTH-1:0][7:0] held_t;

	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [2:0]              count;
		logic                    text_end;
	} rec_t;

	typedef struct packed {
		logic valid;
		rec_t rec;
	} push_t;

	typedef struct packed {
		logic       full;
		logic       prefix;
		logic [7:0] dec;
	} match_t;

	// held bytes 0..n-1 plus c against every entity body
	function automatic match_t ent_match(held_t held, logic [2:0] n, logic [7:0] c);
		match_t m;
		logic   ok;
		m = '0;
		for (int e = 0; e < NUM_ENT; e++) begin
			ok = ({1'b0, n} + 4'd1) <= {1'b0, ENT_LEN[e]};
			for (int i = 0; i < HELD_DEPTH; i++) begin
				if (3'(i) < n && held[i] != ENT_BODY[e][i]) begin
					ok = 1'b0;
				end
			end
			if (n > 3'(HELD_DEPTH)) begin
				ok = 1'b0;
			end else if (c != ENT_BODY[e][n]) begin
				ok = 1'b0;
			end
			if (ok) begin
				if (({1'b0, n} + 4'd1) == {1'b0, ENT_LEN[e]}) begin
					m.full = 1'b1;
					m.dec  = ENT_DEC[e];
				end else begin
					m.prefix = 1'b1;
				end
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== design/tsed_front.sv =====
// Front end of the tag strip entity decoder: markup filter, entity matcher
// and result record builder. Depends on tsed_pkg.
`default_nettype none
`include "tag_strip_entity_decoder_defines.svh"

module tsed_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            end_of_input,
	input  logic            q_full,
	output tsed_pkg::push_t push
);
	import tsed_pkg::*;

	logic       inside_q;
	logic       amp_q;
	logic [2:0] cnt_q;
	held_t      held_q;

	logic       accept;
	logic       feed;
	match_t     mt;
	logic       flush_old;
	logic       emit1;
	logic [7:0] b1;
	logic       amp2;
	logic [2:0] cnt2;
	held_t      held2;
	logic       inside2;
	logic [7:0] arr [8];
	logic [3:0] k;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign feed     = (in_byte != CHR_LT) && (in_byte != CHR_GT) && !inside_q;

	always_comb begin
		mt        = ent_match(held_q, cnt_q, in_byte);
		flush_old = 1'b0;
		emit1     = 1'b0;
		b1        = in_byte;
		amp2      = amp_q;
		cnt2      = cnt_q;
		held2     = held_q;
		if (feed) begin
			if (amp_q && mt.full) begin
				emit1 = 1'b1;
				b1    = mt.dec;
				amp2  = 1'b0;
				cnt2  = '0;
			end else if (amp_q && mt.prefix && cnt_q < 3'(HELD_DEPTH)) begin
				held2[cnt_q[1:0]] = in_byte;
				cnt2              = cnt_q + 3'd1;
			end else begin
				flush_old = amp_q;
				if (in_byte == CHR_AMP) begin
					amp2 = 1'b1;
					cnt2 = '0;
				end else begin
					emit1 = 1'b1;
					amp2  = 1'b0;
					cnt2  = '0;
				end
			end
		end
		if (in_byte == CHR_LT) begin
			inside2 = 1'b1;
		end else if (in_byte == CHR_GT) begin
			inside2 = 1'b0;
		end else begin
			inside2 = inside_q;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			arr[i] = '0;
		end
		k = '0;
		if (flush_old) begin
			arr[0] = CHR_AMP;
			for (int i = 0; i < HELD_DEPTH; i++) begin
				if (3'(i) < cnt_q) begin
					arr[i + 1] = held_q[i];
				end
			end
			k = {1'b0, cnt_q} + 4'd1;
		end
		if (emit1) begin
			arr[k[2:0]] = b1;
			k = k + 4'd1;
		end
		if (end_of_input && amp2) begin
			arr[k[2:0]] = CHR_AMP;
			for (int i = 0; i < HELD_DEPTH; i++) begin
				if (3'(i) < cnt2) begin
					arr[3'(k + 4'(i) + 4'd1)] = held2[i];
				end
			end
			k = k + {1'b0, cnt2} + 4'd1;
		end
		for (int i = 0; i < MAX_RES; i++) begin
			push.rec.bytes[i] = arr[i];
		end
		push.rec.count    = k[2:0];
		push.rec.text_end = end_of_input;
		push.valid        = accept && (k != 4'd0 || end_of_input);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			amp_q    <= 1'b0;
			cnt_q    <= '0;
			held_q   <= '0;
		end else if (accept) begin
			if (end_of_input) begin
				inside_q <= 1'b0;
				amp_q    <= 1'b0;
				cnt_q    <= '0;
				held_q   <= '0;
			end else begin
				inside_q <= inside2;
				amp_q    <= amp2;
				cnt_q    <= cnt2;
				held_q   <= held2;
			end
		end
	end

	`TSED_ASSERT_IMP(a_held_bound, clk, arst_n, 1'b1, cnt_q <= 3'(HELD_DEPTH), "held count out of range")
	`TSED_ASSERT_IMP(a_idle_empty, clk, arst_n, !amp_q, cnt_q == 3'd0, "held bytes without pending amp")
	`TSED_ASSERT_NXT(a_end_clear, clk, arst_n, accept && end_of_input, !amp_q && !inside_q, "state not cleared at end of text")

endmodule

`default_nettype wire

// ===== design/tsed_queue.sv =====
// Record queue between the front and back ends of the tag strip entity
// decoder, held in flip-flops. Depends on tsed_pkg.
`default_nettype none
`include "tag_strip_entity_decoder_defines.svh"

module tsed_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tsed_pkg::push_t push,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output tsed_pkg::rec_t  head
);
	import tsed_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rec_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full       = cnt_q == CW'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push.valid && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push.valid) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	`TSED_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH), "queue count overflow")
	`TSED_ASSERT_IMP(a_pop_empty, clk, arst_n, pop, cnt_q != '0, "pop from empty queue")
	`TSED_ASSERT_IMP(a_push_full, clk, arst_n, push.valid, !full, "push into full queue")

endmodule

`default_nettype wire

// ===== design/tsed_back.sv =====
// Back end of the tag strip entity decoder; depends on tsed_pkg. Walks each queued
// record, driving one result word per cycle unless stalled, via an output register.
`default_nettype none
`include "tag_strip_entity_decoder_defines.svh"

module tsed_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  tsed_pkg::rec_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           byte_present,
	output logic           run_last,
	output logic           text_done
);
	import tsed_pkg::*;

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       present_q;
	logic       last_q;
	logic       done_q;
	logic       load;
	logic       rec_last;

	assign load     = head_valid && (!valid_q || out_ready);
	assign rec_last = (head.count == 3'd0) || (idx_q == head.count - 3'd1);
	assign pop      = load && rec_last;

	assign out_valid    = valid_q;
	assign out_byte     = byte_q;
	assign byte_present = present_q;
	assign run_last     = last_q;
	assign text_done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= rec_last ? 3'd0 : idx_q + 3'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q    <= (head.count == 3'd0) ? 8'd0 : head.bytes[idx_q];
			present_q <= head.count != 3'd0;
			last_q    <= rec_last;
			done_q    <= rec_last && head.text_end;
		end
	end

	`TSED_ASSERT_IMP(a_idx_bound, clk, arst_n, head_valid && head.count != 3'd0, idx_q < head.count, "record index past count")
	`TSED_ASSERT_IMP(a_done_last, clk, arst_n, valid_q && done_q, last_q, "text end not on last word")
	`TSED_ASSERT_IMP(a_empty_done, clk, arst_n, valid_q && !present_q, done_q, "empty word before end of text")

endmodule

`default_nettype wire

// ===== design/tag_strip_entity_decoder.sv =====
// An accepted byte's results are registered in the queue, then in the output register.
// Throughput: one input byte and one result word per cycle, unless a full queue or a low
// m_tready stalls; the QUEUE_DEPTH-record queue keeps input flowing past a busy back end.
// Reset: arst_n clears markup, entity and queue state at once; no clearing pass.
// Top level; depends on tsed_pkg, tsed_front, tsed_queue and tsed_back.
`default_nettype none

module tag_strip_entity_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // end_of_input
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [1:0] m_tuser,   // [0] byte_present, [1] text_done
	output logic       m_tlast    // run_last
);
	import tsed_pkg::*;

	push_t push;
	rec_t  head;
	logic  q_full;
	logic  head_valid;
	logic  pop;

	tsed_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_byte      (s_tdata),
		.end_of_input (s_tlast),
		.q_full       (q_full),
		.push         (push)
	);

	tsed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	tsed_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_byte     (m_tdata),
		.byte_present (m_tuser[0]),
		.run_last     (m_tlast),
		.text_done    (m_tuser[1])
	);

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking bench for tag_strip_entity_decoder: a scoreboard class predicts
// the decoded text from each accepted input word and checks every result word.
// Depends on tsed_pkg and the tag_strip_entity_decoder RTL.
`default_nettype none

module tb;
	import tsed_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       run_end;
		logic       done;
	} text_word_t;

	typedef struct {
		logic [7:0] data;
		bit         last;
	} raw_byte_t;

	class decode_scoreboard;
		string      ent_name[5];
		logic [7:0] ent_char[5];
		bit         in_markup;
		bit         amp_seen;
		int         held_n;
		logic [7:0] held[4];
		text_word_t burst[$];
		text_word_t expected_text[$];
		int         errors;
		int         words_checked;
		int         texts;

		function new();
			ent_name = '{"amp;", "lt;", "gt;", "quot;", "apos;"};
			ent_char = '{CHR_AMP, CHR_LT, CHR_GT, CHR_QUOT, CHR_APOS};
			errors = 0;
			words_checked = 0;
			texts = 0;
			clear();
		endfunction

		function void clear();
			in_markup = 0;
			amp_seen = 0;
			held_n = 0;
			foreach (held[i]) held[i] = '0;
		endfunction

		function void put_char(logic [7:0] c);
			burst.insert(burst.size(), text_word_t'{c, 1'b1, 1'b0, 1'b0});
		endfunction

		function void spill_amp();
			put_char(CHR_AMP);
			for (int i = 0; i < held_n; i++) put_char(held[i]);
			amp_seen = 0;
			held_n = 0;
		endfunction

		// 0: no entity fits, 1: proper prefix, 2: full entity in dec
		function int entity_match(logic [7:0] cand[5], int n, output logic [7:0] dec);
			int    best;
			bit    ok;
			string s;
			best = 0;
			dec = '0;
			for (int e = 0; e < 5; e++) begin
				s = ent_name[e];
				if (n > s.len()) continue;
				ok = 1;
				for (int i = 0; i < n; i++) begin
					if (8'(s[i]) != cand[i]) ok = 0;
				end
				if (!ok) continue;
				if (n == s.len()) begin
					dec = ent_char[e];
					return 2;
				end
				best = 1;
			end
			return best;
		endfunction

		function void decode_char(logic [7:0] c);
			logic [7:0] cand[5];
			logic [7:0] dec;
			int         r;
			if (amp_seen) begin
				foreach (cand[i]) cand[i] = '0;
				for (int i = 0; i < held_n; i++) cand[i] = held[i];
				cand[held_n] = c;
				r = entity_match(cand, held_n + 1, dec);
				if (r == 2) begin
					amp_seen = 0;
					held_n = 0;
					put_char(dec);
					return;
				end
				if (r == 1 && held_n < 4) begin
					held[held_n] = c;
					held_n++;
					return;
				end
				spill_amp();
			end
			if (c == CHR_AMP) begin
				amp_seen = 1;
				held_n = 0;
				return;
			end
			put_char(c);
		endfunction

		function void note_byte(logic [7:0] c, bit last);
			burst.delete();
			if (c == CHR_LT) begin
				in_markup = 1;
			end else if (c == CHR_GT) begin
				in_markup = 0;
			end else if (!in_markup) begin
				decode_char(c);
			end
			if (last) begin
				if (amp_seen) spill_amp();
				if (burst.size() == 0) begin
					burst.insert(0, text_word_t'{8'h00, 1'b0, 1'b0, 1'b0});
				end
				burst[burst.size() - 1].done = 1'b1;
				clear();
				texts++;
			end
			if (burst.size() != 0) burst[burst.size() - 1].run_end = 1'b1;
			foreach (burst[i]) expected_text.insert(expected_text.size(), burst[i]);
		endfunction

		function void field_err(string name, int exp_v, int act_v);
			errors++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
		endfunction

		function void check_word(logic [7:0] data, logic present, logic run_end, logic done);
			text_word_t exp_w;
			if (expected_text.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: expected none, actual data %02h present %0b last %0b done %0b",
					$time, data, present, run_end, done);
				return;
			end
			exp_w = expected_text.pop_front();
			words_checked++;
			if (data !== exp_w.data) field_err("out_byte", int'(exp_w.data), int'(data));
			if (present !== exp_w.present) begin
				field_err("byte_present", int'(exp_w.present), int'(present));
			end
			if (run_end !== exp_w.run_end) field_err("run_last", int'(exp_w.run_end), int'(run_end));
			if (done !== exp_w.done) field_err("text_done", int'(exp_w.done), int'(done));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	decode_scoreboard sb;
	raw_byte_t        text_q[$];
	bit               calm = 0;

	always #5 clk = ~clk;

	tag_strip_entity_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	function void add_byte(logic [7:0] b, bit last);
		text_q.insert(text_q.size(), raw_byte_t'{b, last});
	endfunction

	function void add_str(string s, bit last);
		for (int i = 0; i < s.len(); i++) add_byte(8'(s[i]), last && (i == s.len() - 1));
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
	end

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int    e;
		int    k;
		string s;
		sb = new();

		add_str("&gt;", 0);
		add_str("&a<>pos;", 0);
		add_str(">", 0);
		add_byte(8'h00, 0);
		add_byte(8'hff, 0);
		add_str("&q!", 0);
		add_str("&amp", 1);
		add_str("<", 1);

		while (text_q.size() < 325) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					add_byte(CHR_AMP, 0);
					add_str(sb.ent_name[$urandom_range(0, 4)], 0);
				end
				3, 4: begin
					e = $urandom_range(0, 4);
					s = sb.ent_name[e];
					k = $urandom_range(0, s.len() - 1);
					add_byte(CHR_AMP, 0);
					add_str(s.substr(0, k - 1), 0);
					add_byte(8'($urandom_range(0, 255)), 0);
				end
				5: begin
					add_byte(CHR_LT, 0);
					repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)), 0);
					add_byte(CHR_GT, 0);
				end
				6: begin
					add_byte(8'($urandom_range(0, 255)), 0);
				end
				default: begin
					add_byte(8'($urandom_range(8'h20, 8'h7e)), 0);
				end
			endcase
			if ($urandom_range(0, 11) == 0) text_q[text_q.size() - 1].last = 1'b1;
		end
		text_q[text_q.size() - 1].last = 1'b1;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (text_q[i]) begin
			if (i >= text_q.size() - 60) calm = 1;
			if (!calm && $urandom_range(0, 4) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= text_q[i].data;
			s_tlast <= text_q[i].last;
			do @(posedge clk); while (!s_tready);
			sb.note_byte(text_q[i].data, text_q[i].last);
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		while (sb.expected_text.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Fed %0d bytes in %0d texts; %0d result words checked, %0d errors.",
			text_q.size(), sb.texts, sb.words_checked, sb.errors);
		if (sb.errors == 0 && sb.expected_text.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
